FILE: rtl/core/greedy_word_wrap_paginator_macros.svh
// assertion helpers used by the paginator wrap core
// both expect i_clk and i_rst_n in scope
`ifndef GREEDY_WORD_WRAP_PAGINATOR_MACROS_SVH
`define GREEDY_WORD_WRAP_PAGINATOR_MACROS_SVH

// condition holds on every clock out of reset
`define GWWP_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gwwp check failed");

// trigger in one cycle implies consequence in the next
`define GWWP_CHECK_NEXT(label, trig, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("gwwp next-cycle check failed");

`endif

FILE: rtl/core/gwwp_pkg.sv
package gwwp_pkg;

    localparam int OFFSET_W = 32;
    localparam int LEN_W    = 7;
    localparam int PAGE_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic CMD_TEXT  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [LEN_W-1:0]    LINE_WIDTH_RST     = 7'd49;
    localparam logic [PAGE_W-1:0]   LINES_PER_PAGE_RST = 6'd25;
    localparam logic [OFFSET_W-1:0] START_OFFSET_RST   = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH     = 2'd0,
        REG_LINES_PER_PAGE = 2'd1,
        REG_START_OFFSET   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0]  line_width;
        logic [PAGE_W-1:0] lines_per_page;
    } t_cfg;

    typedef struct packed {
        logic [OFFSET_W-1:0] line_offset;
        logic [LEN_W-1:0]    line_length;
        logic [PAGE_W-1:0]   line_index;
        logic                page_end;
        logic [OFFSET_W-1:0] next_offset;
        logic                text_end;
    } t_result;

endpackage

FILE: rtl/core/gwwp_ifs.sv
interface gwwp_in_if;
    import gwwp_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output cmd, output text_byte, input ready);
    modport sink   (input valid, input cmd, input text_byte, output ready);
endinterface

interface gwwp_out_if;
    import gwwp_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] line_offset;
    logic [LEN_W-1:0]    line_length;
    logic [PAGE_W-1:0]   line_index;
    logic                page_end;
    logic [OFFSET_W-1:0] next_offset;
    logic                text_end;

    modport source (output valid, output line_offset, output line_length,
                    output line_index, output page_end, output next_offset,
                    output text_end, input ready);
    modport sink   (input valid, input line_offset, input line_length,
                    input line_index, input page_end, input next_offset,
                    input text_end, output ready);
endinterface

interface gwwp_cfg_if;
    import gwwp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [OFFSET_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/gwwp_wrap_core.sv
`include "greedy_word_wrap_paginator_macros.svh"

module gwwp_wrap_core #(
    parameter int LINE_CAP       = 96,
    parameter int PAGE_LINES_CAP = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_cmd,
    input  logic [gwwp_pkg::BYTE_W-1:0]       i_text_byte,
    input  gwwp_pkg::t_cfg                    i_cfg,
    input  logic                              i_restart,
    input  logic [gwwp_pkg::OFFSET_W-1:0]     i_restart_at,
    output logic                              o_emit,
    output gwwp_pkg::t_result                 o_res
);
    import gwwp_pkg::*;

    localparam int CW = $clog2(LINE_CAP);
    localparam logic [7:0] LIMIT_MAX = 8'(LINE_CAP - 1);
    localparam logic [6:0] PAGE_MAX  = 7'(PAGE_LINES_CAP);

    logic [OFFSET_W-1:0] r_byte_pos, n_byte_pos;
    logic [OFFSET_W-1:0] r_line_start, n_line_start;
    logic [CW-1:0]       r_line_count, n_line_count;
    logic                r_space_seen, n_space_seen;
    logic [OFFSET_W-1:0] r_space_offset, n_space_offset;
    logic [CW-1:0]       r_space_column, n_space_column;
    logic [CW-1:0]       r_tail_count, n_tail_count;
    logic [PAGE_W-1:0]   r_page_idx, n_page_idx;

    logic [7:0]          width_clamped;
    logic [CW-1:0]       limit;
    logic [6:0]          page_size;
    logic                page_full;
    logic [CW:0]         count_inc;
    logic                is_space;
    logic                seen;
    logic [OFFSET_W-1:0] soff;
    logic [CW-1:0]       scol;
    logic [CW-1:0]       tail;
    logic [CW-1:0]       len;
    logic [CW+LEN_W-1:0] len_ext;

    // clamp configured limits into their legal ranges
    always_comb begin
        width_clamped = {1'b0, i_cfg.line_width};
        if (width_clamped == 8'd0) begin
            width_clamped = 8'd1;
        end
        if (width_clamped > LIMIT_MAX) begin
            width_clamped = LIMIT_MAX;
        end
        limit = width_clamped[CW-1:0];

        page_size = {1'b0, i_cfg.lines_per_page};
        if (page_size == 7'd0) begin
            page_size = 7'd1;
        end
        if (page_size > PAGE_MAX) begin
            page_size = PAGE_MAX;
        end
    end

    assign page_full = ({1'b0, r_page_idx} + 7'd1) >= page_size;
    assign count_inc = {1'b0, r_line_count} + {{CW{1'b0}}, 1'b1};
    assign is_space  = (i_text_byte == CHAR_SPACE);
    assign seen      = r_space_seen | is_space;
    assign soff      = is_space ? r_byte_pos : r_space_offset;
    assign scol      = is_space ? r_line_count : r_space_column;
    assign tail      = is_space ? '0 : r_tail_count + {{(CW-1){1'b0}}, 1'b1};

    always_comb begin
        n_byte_pos     = r_byte_pos;
        n_line_start   = r_line_start;
        n_line_count   = r_line_count;
        n_space_seen   = r_space_seen;
        n_space_offset = r_space_offset;
        n_space_column = r_space_column;
        n_tail_count   = r_tail_count;
        n_page_idx     = r_page_idx;
        o_emit         = 1'b0;
        len            = r_line_count;
        o_res.line_offset = r_line_start;
        o_res.next_offset = r_byte_pos;
        o_res.text_end    = 1'b0;
        o_res.line_index  = r_page_idx;
        o_res.page_end    = page_full;

        if (i_restart) begin
            n_byte_pos     = i_restart_at;
            n_line_start   = i_restart_at;
            n_line_count   = '0;
            n_space_seen   = 1'b0;
            n_space_offset = '0;
            n_space_column = '0;
            n_tail_count   = '0;
            n_page_idx     = '0;
        end else if (i_step) begin
            if (i_cmd == CMD_FLUSH) begin
                o_emit         = 1'b1;
                o_res.text_end = 1'b1;
                n_line_start   = r_byte_pos;
                n_line_count   = '0;
                n_space_seen   = 1'b0;
                n_space_offset = '0;
                n_space_column = '0;
                n_tail_count   = '0;
                n_page_idx     = '0;
            end else begin
                n_byte_pos = r_byte_pos + 32'd1;
                case (i_text_byte)
                    CHAR_CR: begin
                    end
                    CHAR_LF: begin
                        o_emit            = 1'b1;
                        o_res.next_offset = r_byte_pos + 32'd1;
                        n_line_start      = r_byte_pos + 32'd1;
                        n_line_count      = '0;
                        n_space_seen      = 1'b0;
                        n_space_offset    = '0;
                        n_space_column    = '0;
                        n_tail_count      = '0;
                        n_page_idx        = page_full ? '0 : r_page_idx + 6'd1;
                    end
                    default: begin
                        if (count_inc >= {1'b0, limit}) begin
                            o_emit     = 1'b1;
                            n_page_idx = page_full ? '0 : r_page_idx + 6'd1;
                            n_space_seen   = 1'b0;
                            n_space_offset = '0;
                            n_space_column = '0;
                            if (seen) begin
                                // break at last space, tail carries over
                                len               = scol;
                                o_res.next_offset = soff + 32'd1;
                                n_line_start      = soff + 32'd1;
                                n_line_count      = tail;
                                n_tail_count      = tail;
                            end else begin
                                // hard cut at the limit
                                len               = count_inc[CW-1:0];
                                o_res.next_offset = r_byte_pos + 32'd1;
                                n_line_start      = r_byte_pos + 32'd1;
                                n_line_count      = '0;
                                n_tail_count      = '0;
                            end
                        end else begin
                            n_line_count   = count_inc[CW-1:0];
                            n_space_seen   = seen;
                            n_space_offset = soff;
                            n_space_column = scol;
                            n_tail_count   = tail;
                        end
                    end
                endcase
            end
        end

        len_ext           = {{LEN_W{1'b0}}, len};
        o_res.line_length = len_ext[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= START_OFFSET_RST;
            r_line_start   <= START_OFFSET_RST;
            r_line_count   <= '0;
            r_space_seen   <= 1'b0;
            r_space_offset <= '0;
            r_space_column <= '0;
            r_tail_count   <= '0;
            r_page_idx     <= '0;
        end else begin
            r_byte_pos     <= n_byte_pos;
            r_line_start   <= n_line_start;
            r_line_count   <= n_line_count;
            r_space_seen   <= n_space_seen;
            r_space_offset <= n_space_offset;
            r_space_column <= n_space_column;
            r_tail_count   <= n_tail_count;
            r_page_idx     <= n_page_idx;
        end
    end

    `GWWP_CHECK(a_count_in_range, {1'b0, r_line_count} <= {1'b0, LIMIT_MAX[CW-1:0]})
    `GWWP_CHECK(a_tail_within_line, r_tail_count <= r_line_count)
    `GWWP_CHECK(a_space_within_line, !r_space_seen || (r_space_column <= r_line_count))
    `GWWP_CHECK_NEXT(a_page_wraps, o_emit && o_res.page_end, r_page_idx == '0)
    `GWWP_CHECK_NEXT(a_restart_aligns, i_restart,
        (r_line_start == r_byte_pos) && (r_line_count == '0) && (r_page_idx == '0))

endmodule

FILE: rtl/core/greedy_word_wrap_paginator.sv
// channel   dir  handshake      payload
// i_in      in   valid/ready    cmd, text_byte
// o_out     out  valid/ready    line_offset, line_length, line_index, page_end,
//                               next_offset, text_end
// i_cfg     in   valid/ready    index, data (ready always high)
//
// one word per cycle sustained: input register, one pass through the wrap core,
// result register; the line for a word is registered in the result register
// carriage returns and visible bytes that do not break a line give no result
// a stalled o_out holds the result register; the input register still takes one
// more word, then i_in.ready drops until the result is taken
// synchronous active-low reset restores line_width 49, lines_per_page 25, offset 0
module greedy_word_wrap_paginator #(
    parameter int LINE_CAP       = 96,
    parameter int PAGE_LINES_CAP = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gwwp_in_if.sink           i_in,
    gwwp_out_if.source        o_out,
    gwwp_cfg_if.sink          i_cfg
);
    import gwwp_pkg::*;

    // input register
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [BYTE_W-1:0] r_in_byte;

    // configuration registers
    logic [LEN_W-1:0]    r_line_width;
    logic [PAGE_W-1:0]   r_lines_per_page;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    in_take;
    logic    cfg_write;
    logic    restart;
    logic    emit;
    t_cfg    cfg;
    t_result res;

    // the input register moves on whenever the result register has room
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid;
    // writing the start offset restarts the stream at that offset
    assign restart     = cfg_write && (i_cfg.index == REG_START_OFFSET);

    assign cfg.line_width     = r_line_width;
    assign cfg.lines_per_page = r_lines_per_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= i_in.cmd;
            r_in_byte <= i_in.text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width     <= LINE_WIDTH_RST;
            r_lines_per_page <= LINES_PER_PAGE_RST;
        end else if (cfg_write) begin
            case (i_cfg.index)
                REG_LINE_WIDTH: begin
                    r_line_width <= i_cfg.data[LEN_W-1:0];
                end
                REG_LINES_PER_PAGE: begin
                    r_lines_per_page <= i_cfg.data[PAGE_W-1:0];
                end
                REG_START_OFFSET: begin
                    // no stored copy, the write restarts the wrap core directly
                end
                default: begin
                end
            endcase
        end
    end

    gwwp_wrap_core #(
        .LINE_CAP       (LINE_CAP),
        .PAGE_LINES_CAP (PAGE_LINES_CAP)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_cmd        (r_in_cmd),
        .i_text_byte  (r_in_byte),
        .i_cfg        (cfg),
        .i_restart    (restart),
        .i_restart_at (i_cfg.data),
        .o_emit       (emit),
        .o_res        (res)
    );

    // result register: loads on a producing step, clears once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.line_offset = r_out.line_offset;
    assign o_out.line_length = r_out.line_length;
    assign o_out.line_index  = r_out.line_index;
    assign o_out.page_end    = r_out.page_end;
    assign o_out.next_offset = r_out.next_offset;
    assign o_out.text_end    = r_out.text_end;

endmodule
